[rtl/core/mts_pkg.sv]
package mts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FREQ_W      = 15;
    localparam int DUR_W       = 15;
    localparam int TIME_W      = 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic {
        SRC_COMPLETED = 1'b0,
        SRC_STOPPED   = 1'b1
    } end_src_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request, read table
        logic execute;   // update state, load result register
    } mts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic res_blocked;   // result register full and stalled
    } mts_status_t;

endpackage

[rtl/core/melody_tone_sequencer_top.sv]
// Melody tone sequencer. Stores up to TABLE_DEPTH (16) tones of (frequency, duration) and
// plays them on tick requests carrying the millisecond clock: add-tone appends to the table,
// start rewinds to the first tone, stop silences with an end event of source "stopped", and
// when the last tone runs out the melody wraps (repeat_mode = 1) or ends with source
// "completed". Each request yields exactly one result. A request is first captured, with the
// current table entry read (the table has one registered read port); then the play state is
// updated and the result register loaded. The next request is taken the cycle after that
// update, while the previous result may still sit in the result register; the update only
// waits while that register is still full and stalled, and req_stall holds off new requests.
// repeat_mode is written through the cfg channel, which is always ready; write it only
// while no request is in progress. The tone table has no reset and needs no clearing pass.
module melody_tone_sequencer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  action,
    input  logic [mts_pkg::FREQ_W-1:0]  tone_frequency,
    input  logic [mts_pkg::DUR_W-1:0]   tone_duration,
    input  logic [mts_pkg::TIME_W-1:0]  current_time,
    // result channel
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        add_accepted,
    output logic                        tone_start,
    output logic [mts_pkg::FREQ_W-1:0]  tone_frequency_out,
    output logic [mts_pkg::DUR_W-1:0]   tone_duration_out,
    output logic                        silence,
    output logic                        end_event,
    output logic                        end_source,
    output logic                        running_flag,
    // repeat_mode write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import mts_pkg::*;

    mts_cmd_t    cmd;
    mts_status_t status;

    assign cfg_ready = 1'b1;

    // sequencing: capture -> execute, with back-pressure from the result register
    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // table, play state, timing compare and result register
    mts_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .action             (action),
        .tone_frequency     (tone_frequency),
        .tone_duration      (tone_duration),
        .current_time       (current_time),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .add_accepted       (add_accepted),
        .tone_start         (tone_start),
        .tone_frequency_out (tone_frequency_out),
        .tone_duration_out  (tone_duration_out),
        .silence            (silence),
        .end_event          (end_event),
        .end_source         (end_source),
        .running_flag       (running_flag)
    );

endmodule

[rtl/core/mts_ctrl.sv]
module mts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mts_pkg::mts_status_t status,
    output mts_pkg::mts_cmd_t    cmd
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!status.res_blocked)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a captured request is always followed by its execute before the next capture
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("capture repeated without execute");

    a_exec_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !status.res_blocked)
        else $error("execute while result register blocked");

    a_stall_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> req_stall)
        else $error("request side open during execute");

endmodule

[rtl/core/mts_dp.sv]
module mts_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mts_pkg::mts_cmd_t           cmd,
    output mts_pkg::mts_status_t        status,
    input  logic [1:0]                  action,
    input  logic [mts_pkg::FREQ_W-1:0]  tone_frequency,
    input  logic [mts_pkg::DUR_W-1:0]   tone_duration,
    input  logic [mts_pkg::TIME_W-1:0]  current_time,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        add_accepted,
    output logic                        tone_start,
    output logic [mts_pkg::FREQ_W-1:0]  tone_frequency_out,
    output logic [mts_pkg::DUR_W-1:0]   tone_duration_out,
    output logic                        silence,
    output logic                        end_event,
    output logic                        end_source,
    output logic                        running_flag
);
    import mts_pkg::*;

    localparam int ENTRY_W = FREQ_W + DUR_W;

    // tone table: {frequency, duration}
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    // captured request
    action_t             action_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;

    // sequencer state
    logic [CNT_W-1:0]    fill_count_reg;
    logic [CNT_W-1:0]    fill_count_next;
    logic [CNT_W-1:0]    play_index_reg;
    logic [CNT_W-1:0]    play_index_next;
    logic [TIME_W-1:0]   tone_start_time_reg;
    logic [TIME_W-1:0]   tone_start_time_next;
    logic                playing_reg;
    logic                playing_next;
    logic                tone_pending_reg;
    logic                tone_pending_next;
    logic                repeat_mode_reg;

    // result register
    logic                res_valid_reg;
    logic                add_accepted_reg;
    logic                add_accepted_next;
    logic                tone_start_reg;
    logic                tone_start_next;
    logic [FREQ_W-1:0]   tone_freq_reg;
    logic [FREQ_W-1:0]   tone_freq_next;
    logic [DUR_W-1:0]    tone_dur_reg;
    logic [DUR_W-1:0]    tone_dur_next;
    logic                silence_reg;
    logic                silence_next;
    logic                end_event_reg;
    logic                end_event_next;
    end_src_t            end_source_reg;
    end_src_t            end_source_next;
    logic                running_flag_reg;

    logic [IDX_W-1:0]    rd_addr;
    logic                table_full;
    logic                mem_we;
    logic [FREQ_W-1:0]   cur_freq;
    logic [DUR_W-1:0]    cur_dur;
    logic [CNT_W-1:0]    idx;
    logic [TIME_W-1:0]   start_t;
    logic [TIME_W-1:0]   diff;

    assign table_full = (fill_count_reg >= CNT_W'(TABLE_DEPTH));
    // past the end wraps to the first tone before reading
    assign rd_addr    = (play_index_reg >= fill_count_reg) ? '0 : play_index_reg[IDX_W-1:0];
    assign mem_we     = cmd.execute && (action_reg == ACT_ADD) && !table_full;
    assign cur_freq   = rd_data_reg[ENTRY_W-1:DUR_W];
    assign cur_dur    = rd_data_reg[DUR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fill_count_reg[IDX_W-1:0]] <= {freq_reg, dur_reg};
        end
        if (cmd.capture)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(action);
            freq_reg   <= tone_frequency;
            dur_reg    <= tone_duration;
            time_reg   <= current_time;
        end
    end

    always_comb
    begin
        fill_count_next      = fill_count_reg;
        play_index_next      = play_index_reg;
        tone_start_time_next = tone_start_time_reg;
        playing_next         = playing_reg;
        tone_pending_next    = tone_pending_reg;
        add_accepted_next    = 1'b0;
        tone_start_next      = 1'b0;
        tone_freq_next       = '0;
        tone_dur_next        = '0;
        silence_next         = 1'b0;
        end_event_next       = 1'b0;
        end_source_next      = SRC_COMPLETED;
        idx                  = (play_index_reg >= fill_count_reg) ? '0 : play_index_reg;
        start_t              = tone_start_time_reg;
        diff                 = '0;

        case (action_reg)
            ACT_TICK:
            begin
                if (playing_reg)
                begin
                    if (fill_count_reg == '0)
                    begin
                        if (!repeat_mode_reg)
                        begin
                            playing_next   = 1'b0;
                            silence_next   = 1'b1;
                            end_event_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (tone_pending_reg)
                        begin
                            if (cur_freq != '0)
                            begin
                                tone_start_next = 1'b1;
                                tone_freq_next  = cur_freq;
                                tone_dur_next   = cur_dur;
                            end
                            tone_pending_next = 1'b0;
                            start_t           = time_reg;
                        end
                        diff = time_reg - start_t;
                        // wrapped elapsed time, read as signed
                        if ($signed(diff) > $signed({{(TIME_W - DUR_W){1'b0}}, cur_dur}))
                        begin
                            idx               = idx + 1'b1;
                            start_t           = time_reg;
                            tone_pending_next = 1'b1;
                        end
                        if (idx >= fill_count_reg)
                        begin
                            if (repeat_mode_reg)
                            begin
                                idx = '0;
                            end
                            else
                            begin
                                playing_next   = 1'b0;
                                silence_next   = 1'b1;
                                end_event_next = 1'b1;
                            end
                        end
                        play_index_next      = idx;
                        tone_start_time_next = start_t;
                    end
                end
            end
            ACT_ADD:
            begin
                if (!table_full)
                begin
                    fill_count_next   = fill_count_reg + 1'b1;
                    add_accepted_next = 1'b1;
                end
            end
            ACT_START:
            begin
                playing_next      = 1'b1;
                play_index_next   = '0;
                tone_pending_next = 1'b1;
            end
            ACT_STOP:
            begin
                playing_next    = 1'b0;
                silence_next    = 1'b1;
                end_event_next  = 1'b1;
                end_source_next = SRC_STOPPED;
            end
            default:
            begin
                playing_next = playing_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg      <= '0;
            play_index_reg      <= '0;
            tone_start_time_reg <= '0;
            playing_reg         <= 1'b0;
            tone_pending_reg    <= 1'b0;
            repeat_mode_reg     <= 1'b0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                repeat_mode_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                fill_count_reg      <= fill_count_next;
                play_index_reg      <= play_index_next;
                tone_start_time_reg <= tone_start_time_next;
                playing_reg         <= playing_next;
                tone_pending_reg    <= tone_pending_next;
                res_valid_reg       <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            add_accepted_reg <= add_accepted_next;
            tone_start_reg   <= tone_start_next;
            tone_freq_reg    <= tone_freq_next;
            tone_dur_reg     <= tone_dur_next;
            silence_reg      <= silence_next;
            end_event_reg    <= end_event_next;
            end_source_reg   <= end_source_next;
            running_flag_reg <= playing_next;
        end
    end

    assign status.res_blocked = res_valid_reg && res_stall;

    assign res_valid          = res_valid_reg;
    assign add_accepted       = add_accepted_reg;
    assign tone_start         = tone_start_reg;
    assign tone_frequency_out = tone_freq_reg;
    assign tone_duration_out  = tone_dur_reg;
    assign silence            = silence_reg;
    assign end_event          = end_event_reg;
    assign end_source         = end_source_reg;
    assign running_flag       = running_flag_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_index_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        play_index_reg <= fill_count_reg)
        else $error("play index beyond fill count");

    a_end_stops_play: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && end_event_reg |-> !running_flag_reg && silence_reg)
        else $error("end event while still running");

    a_tone_not_rest: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && tone_start_reg |-> (tone_freq_reg != '0) && !silence_reg)
        else $error("tone command with rest frequency or silence");

endmodule
